// ----- design/fcca_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and helper functions of the fat cluster chain allocator
// no dependencies

package fcca_pkg;

  localparam int FAT_BYTES = 8192;
  localparam int ADDR_W    = $clog2(FAT_BYTES);
  localparam int OFF_W     = 24;
  localparam int CL_W      = 21;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FAT_BYTES - 1);
  localparam logic [OFF_W-1:0]  STORE_END = OFF_W'(FAT_BYTES);

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_START = 3'd1,
    OP_CONT  = 3'd2,
    OP_END   = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_COUNT  = 2'd1,
    CFG_MEDIA  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ENT_CHK,
    ST_ENT_BYTE,
    ST_ENT_MRG,
    ST_ADV_INC,
    ST_ADV_OFF,
    ST_ADV_CHK,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [12:0] read_addr;
  } item_t;

  typedef struct packed {
    logic [19:0] cluster;
    logic [7:0]  read_data;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [1:0]      fat_format;
    logic [CL_W-1:0] cluster_count;
    logic [7:0]      media_byte;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [OFF_W-1:0] entry_offset(input logic [CL_W-1:0] c,
                                                    input logic [1:0] fmt);
    logic [OFF_W-1:0] cw;
    logic [OFF_W-1:0] c3;
    cw = OFF_W'(c);
    c3 = cw + (cw << 1);
    if (fmt == 2'd0) begin
      return c3 >> 1;
    end else if (fmt == 2'd1) begin
      return cw << 1;
    end
    return cw << 2;
  endfunction

  function automatic logic entry_fits(input logic [OFF_W-1:0] off,
                                      input logic [1:0] fmt);
    logic [OFF_W-1:0] size;
    size = fmt[1] ? OFF_W'(4) : OFF_W'(2);
    return (off + size) <= STORE_END;
  endfunction

  function automatic logic [7:0] entry_byte(input logic [1:0] fmt, input logic odd,
                                            input logic [1:0] k, input logic [31:0] x,
                                            input logic [7:0] old);
    logic [7:0] b;
    b = 8'h00;
    if (fmt == 2'd0) begin
      if (odd) begin
        b = (k == 2'd0) ? {x[3:0], old[3:0]} : x[11:4];
      end else begin
        b = (k == 2'd0) ? x[7:0] : {old[7:4], x[11:8]};
      end
    end else if (fmt == 2'd1) begin
      b = (k == 2'd0) ? x[7:0] : x[15:8];
    end else begin
      case (k)
        2'd0:    b = x[7:0];
        2'd1:    b = x[15:8];
        2'd2:    b = x[23:16];
        default: b = {4'h0, x[27:24]};
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [ADDR_W-1:0] addr,
                                          input logic [1:0] fmt,
                                          input logic [7:0] media);
    logic [7:0] b;
    b = 8'h00;
    if (addr[ADDR_W-1:3] == '0) begin
      case (addr[2:0])
        3'd0:    b = media;
        3'd1:    b = 8'hff;
        3'd2:    b = 8'hff;
        3'd3:    b = (fmt != 2'd0) ? 8'hff : 8'h00;
        default: b = fmt[1] ? 8'hff : 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- design/fcca_table.sv -----
`timescale 1ns / 1ps
// byte store holding the allocation table: one write port, one registered read port
// depends on fcca_pkg

module fcca_table (
  input  logic                          clk,
  input  fcca_pkg::mem_req_t            req,
  output logic [7:0]                    rd_data
);

  logic [7:0] mem [fcca_pkg::FAT_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

// ----- design/fcca_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer: clear sweep, entry read-modify-write, cluster advance and byte read
// depends on fcca_pkg; drives fcca_table through a request struct

module fcca_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  fcca_pkg::cfg_t        cfg,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  fcca_pkg::item_t       item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output fcca_pkg::result_t     res,
  output fcca_pkg::mem_req_t    req,
  input  logic [7:0]            rd_data
);

  fcca_pkg::state_t state, state_next;

  logic                          hdr_en, hdr_en_next;
  logic [fcca_pkg::ADDR_W-1:0]   clear_index, clear_index_next;
  logic [fcca_pkg::CL_W-1:0]     last_cluster, last_cluster_next;
  logic [fcca_pkg::OFF_W-1:0]    e_off, e_off_next;
  logic [31:0]                   e_val, e_val_next;
  logic                          e_odd, e_odd_next;
  logic                          e_adv, e_adv_next;
  logic [1:0]                    byte_k, byte_k_next;
  logic [fcca_pkg::CL_W-1:0]     nxt, nxt_next;
  logic [fcca_pkg::OFF_W-1:0]    n_off, n_off_next;
  logic                          n_lt, n_lt_next;
  logic                          rd_ok, rd_ok_next;
  fcca_pkg::result_t             res_reg, res_next;

  logic [fcca_pkg::ADDR_W-1:0]   baddr;
  logic [fcca_pkg::OFF_W-1:0]    ra;
  logic                          merge;
  logic                          last_byte;

  assign res = res_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcca_pkg::ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_en       <= 1'b0;
      clear_index  <= '0;
      last_cluster <= fcca_pkg::CL_W'(1);
    end else begin
      hdr_en       <= hdr_en_next;
      clear_index  <= clear_index_next;
      last_cluster <= last_cluster_next;
    end
    e_off   <= e_off_next;
    e_val   <= e_val_next;
    e_odd   <= e_odd_next;
    e_adv   <= e_adv_next;
    byte_k  <= byte_k_next;
    nxt     <= nxt_next;
    n_off   <= n_off_next;
    n_lt    <= n_lt_next;
    rd_ok   <= rd_ok_next;
    res_reg <= res_next;
  end

  always_comb begin
    state_next        = state;
    hdr_en_next       = hdr_en;
    clear_index_next  = clear_index;
    last_cluster_next = last_cluster;
    e_off_next        = e_off;
    e_val_next        = e_val;
    e_odd_next        = e_odd;
    e_adv_next        = e_adv;
    byte_k_next       = byte_k;
    nxt_next          = nxt;
    n_off_next        = n_off;
    n_lt_next         = n_lt;
    rd_ok_next        = rd_ok;
    res_next          = res_reg;
    item_ready        = 1'b0;
    res_valid         = 1'b0;
    req               = '0;

    baddr     = e_off[fcca_pkg::ADDR_W-1:0] + fcca_pkg::ADDR_W'(byte_k);
    ra        = fcca_pkg::OFF_W'(item.read_addr);
    merge     = (cfg.fat_format == 2'd0) &&
                (e_odd ? (byte_k == 2'd0) : (byte_k == 2'd1));
    last_byte = byte_k == (cfg.fat_format[1] ? 2'd3 : 2'd1);

    case (state)
      fcca_pkg::ST_SWEEP: begin
        req.we    = 1'b1;
        req.waddr = clear_index;
        req.wdata = hdr_en ? fcca_pkg::hdr_byte(clear_index, cfg.fat_format, cfg.media_byte)
                           : 8'h00;
        if (clear_index == fcca_pkg::LAST_ADDR) begin
          clear_index_next = '0;
          state_next       = hdr_en ? fcca_pkg::ST_DONE : fcca_pkg::ST_IDLE;
        end else begin
          clear_index_next = clear_index + fcca_pkg::ADDR_W'(1);
        end
      end
      fcca_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        req.raddr  = ra[fcca_pkg::ADDR_W-1:0];
        if (item_valid) begin
          res_next    = '0;
          e_odd_next  = last_cluster[0];
          e_off_next  = fcca_pkg::entry_offset(last_cluster, cfg.fat_format);
          byte_k_next = 2'd0;
          rd_ok_next  = ra < fcca_pkg::STORE_END;
          case (item.operation)
            fcca_pkg::OP_CLEAR: begin
              hdr_en_next       = 1'b1;
              clear_index_next  = '0;
              last_cluster_next = fcca_pkg::CL_W'(1);
              state_next        = fcca_pkg::ST_SWEEP;
            end
            fcca_pkg::OP_START: begin
              state_next = fcca_pkg::ST_ADV_INC;
            end
            fcca_pkg::OP_CONT: begin
              e_val_next = 32'(last_cluster) + 32'd1;
              e_adv_next = 1'b1;
              state_next = fcca_pkg::ST_ENT_CHK;
            end
            fcca_pkg::OP_END: begin
              e_val_next = 32'hffff_ffff;
              e_adv_next = 1'b0;
              state_next = fcca_pkg::ST_ENT_CHK;
            end
            fcca_pkg::OP_READ: begin
              state_next = fcca_pkg::ST_READ;
            end
            default: begin
              state_next = fcca_pkg::ST_DONE;
            end
          endcase
        end
      end
      fcca_pkg::ST_ENT_CHK: begin
        if (fcca_pkg::entry_fits(e_off, cfg.fat_format)) begin
          state_next = fcca_pkg::ST_ENT_BYTE;
        end else begin
          state_next = e_adv ? fcca_pkg::ST_ADV_INC : fcca_pkg::ST_DONE;
        end
      end
      fcca_pkg::ST_ENT_BYTE: begin
        if (merge) begin
          req.raddr  = baddr;
          state_next = fcca_pkg::ST_ENT_MRG;
        end else begin
          req.we    = 1'b1;
          req.waddr = baddr;
          req.wdata = fcca_pkg::entry_byte(cfg.fat_format, e_odd, byte_k, e_val, 8'h00);
          if (last_byte) begin
            state_next = e_adv ? fcca_pkg::ST_ADV_INC : fcca_pkg::ST_DONE;
          end else begin
            byte_k_next = byte_k + 2'd1;
          end
        end
      end
      fcca_pkg::ST_ENT_MRG: begin
        req.we    = 1'b1;
        req.waddr = baddr;
        req.wdata = fcca_pkg::entry_byte(cfg.fat_format, e_odd, byte_k, e_val, rd_data);
        if (last_byte) begin
          state_next = e_adv ? fcca_pkg::ST_ADV_INC : fcca_pkg::ST_DONE;
        end else begin
          byte_k_next = byte_k + 2'd1;
          state_next  = fcca_pkg::ST_ENT_BYTE;
        end
      end
      fcca_pkg::ST_ADV_INC: begin
        nxt_next   = last_cluster + fcca_pkg::CL_W'(1);
        state_next = fcca_pkg::ST_ADV_OFF;
      end
      fcca_pkg::ST_ADV_OFF: begin
        n_lt_next  = nxt < cfg.cluster_count;
        n_off_next = fcca_pkg::entry_offset(nxt, cfg.fat_format);
        state_next = fcca_pkg::ST_ADV_CHK;
      end
      fcca_pkg::ST_ADV_CHK: begin
        if (n_lt && fcca_pkg::entry_fits(n_off, cfg.fat_format)) begin
          last_cluster_next = nxt;
          res_next.cluster  = nxt[19:0];
        end else begin
          res_next.overflow = 1'b1;
        end
        state_next = fcca_pkg::ST_DONE;
      end
      fcca_pkg::ST_READ: begin
        res_next.read_data = rd_ok ? rd_data : 8'h00;
        state_next         = fcca_pkg::ST_DONE;
      end
      fcca_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = fcca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fcca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/fat_cluster_chain_allocator.sv -----
`timescale 1ns / 1ps
// top level of the fat cluster chain allocator: configuration registers, output register
// depends on fcca_pkg, fcca_ctrl and fcca_table
//
//   channel   direction  signals                          payload
//   item      in         item_valid / item_ready          fcca_pkg::item_t
//   result    out        result_valid / result_ready      fcca_pkg::result_t
//   cfg       in         cfg_valid / cfg_ready            cfg_index, cfg_data
//
// one item at a time; all table traffic goes through the one write port and one read port of the byte store
// after reset a zeroing pass over all FAT_BYTES bytes runs before the first item is taken
// a result waits in the output register; the next item is taken meanwhile
// cfg writes are always taken and apply at once

module fat_cluster_chain_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  fcca_pkg::item_t      item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output fcca_pkg::result_t    result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [20:0]          cfg_data
);

  fcca_pkg::cfg_t     cfg;
  fcca_pkg::result_t  res;
  fcca_pkg::mem_req_t req;
  logic               res_valid;
  logic               res_ready;
  logic [7:0]         rd_data;

  assign cfg_ready = 1'b1;
  assign res_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fat_format    <= 2'd0;
      cfg.cluster_count <= fcca_pkg::CL_W'(2048);
      cfg.media_byte    <= 8'hf0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fcca_pkg::CFG_FORMAT: cfg.fat_format    <= cfg_data[1:0];
        fcca_pkg::CFG_COUNT:  cfg.cluster_count <= cfg_data[fcca_pkg::CL_W-1:0];
        fcca_pkg::CFG_MEDIA:  cfg.media_byte    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

  fcca_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .req        (req),
    .rd_data    (rd_data)
  );

  fcca_table u_table (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// ----- bench/fat_cluster_chain_allocator_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the fat cluster chain allocator: table building, chain links, reads
// keeps its own shadow copy of the allocation table and registers to predict every result
// depends on fcca_pkg and fat_cluster_chain_allocator

module fat_cluster_chain_allocator_tb;

  localparam logic [1:0]  FMT12         = 2'd0;
  localparam logic [1:0]  FMT16         = 2'd1;
  localparam logic [1:0]  FMT32         = 2'd2;
  localparam logic [1:0]  FMT32_ALT     = 2'd3;
  localparam logic [2:0]  OP_CODE_MAX   = 3'h7;
  localparam logic [20:0] DEFAULT_COUNT = 21'd2048;
  localparam logic [7:0]  DEFAULT_MEDIA = 8'hf0;
  localparam logic [20:0] COUNT_MAX     = 21'h100000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          IDLE_MARGIN   = 12;
  localparam int          FILL_ITEMS    = 20;
  localparam longint      RUN_LIMIT_NS  = 30_000_000;

  logic    clk;
  logic    rst;
  logic    item_valid = 1'b0;
  logic    item_ready;
  fcca_pkg::item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  fcca_pkg::result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [1:0]  cfg_index;
  logic [20:0] cfg_data;

  fcca_pkg::item_t   pending_items[$];
  fcca_pkg::result_t expected_results[$];
  logic    item_fire;
  int      send_gap;
  int      take_gap;
  int      hold_left;
  int      hold_asked = 0;
  int      hold_done = 0;
  int      items_taken = 0;
  int      failures = 0;
  bit      steady = 1'b0;

  logic [7:0]  fat_shadow [fcca_pkg::FAT_BYTES];
  logic [20:0] shadow_last;
  logic [1:0]  shadow_fmt;
  logic [20:0] shadow_count;
  logic [7:0]  shadow_media;

  fat_cluster_chain_allocator i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("fat_cluster_chain_allocator_tb failed");
    $finish;
  end

  // shadow table model

  function automatic int unsigned slot_pos(int unsigned c, logic [1:0] fmt);
    if (fmt == FMT12) begin
      return (3 * c) / 2;
    end else if (fmt == FMT16) begin
      return 2 * c;
    end
    return 4 * c;
  endfunction

  function automatic bit slot_fits(int unsigned c, logic [1:0] fmt);
    return slot_pos(c, fmt) + (fmt[1] ? 4 : 2) <= fcca_pkg::FAT_BYTES;
  endfunction

  function automatic void store_link(int unsigned c, logic [31:0] x);
    int unsigned o;
    o = slot_pos(c, shadow_fmt);
    if (!slot_fits(c, shadow_fmt)) return;
    if (shadow_fmt == FMT12) begin
      if (c[0]) begin
        fat_shadow[o]     = {x[3:0], fat_shadow[o][3:0]};
        fat_shadow[o + 1] = x[11:4];
      end else begin
        fat_shadow[o]     = x[7:0];
        fat_shadow[o + 1] = {fat_shadow[o + 1][7:4], x[11:8]};
      end
    end else if (shadow_fmt == FMT16) begin
      fat_shadow[o]     = x[7:0];
      fat_shadow[o + 1] = x[15:8];
    end else begin
      fat_shadow[o]     = x[7:0];
      fat_shadow[o + 1] = x[15:8];
      fat_shadow[o + 2] = x[23:16];
      fat_shadow[o + 3] = {4'h0, x[27:24]};
    end
  endfunction

  function automatic void reset_shadow();
    foreach (fat_shadow[i]) fat_shadow[i] = 8'h00;
    shadow_last  = 21'd1;
    shadow_fmt   = FMT12;
    shadow_count = DEFAULT_COUNT;
    shadow_media = DEFAULT_MEDIA;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [20:0] data);
    case (idx)
      fcca_pkg::CFG_FORMAT: shadow_fmt = data[1:0];
      fcca_pkg::CFG_COUNT:  shadow_count = data;
      fcca_pkg::CFG_MEDIA:  shadow_media = data[7:0];
      default:    ;
    endcase
  endfunction

  function automatic fcca_pkg::result_t predict_result(fcca_pkg::item_t it);
    fcca_pkg::result_t res;
    logic [20:0] next;
    res = '0;
    case (it.operation)
      fcca_pkg::OP_CLEAR: begin
        foreach (fat_shadow[i]) fat_shadow[i] = 8'h00;
        fat_shadow[0] = shadow_media;
        fat_shadow[1] = 8'hff;
        fat_shadow[2] = 8'hff;
        if (shadow_fmt != FMT12) fat_shadow[3] = 8'hff;
        if (shadow_fmt[1]) begin
          for (int i = 4; i < 8; i++) fat_shadow[i] = 8'hff;
        end
        shadow_last = 21'd1;
      end
      fcca_pkg::OP_START, fcca_pkg::OP_CONT: begin
        // continue writes its link even when the advance is refused
        if (it.operation == fcca_pkg::OP_CONT) store_link(shadow_last, shadow_last + 1);
        next = shadow_last + 21'd1;
        if (next >= shadow_count || !slot_fits(next, shadow_fmt)) begin
          res.overflow = 1'b1;
        end else begin
          shadow_last = next;
          res.cluster = next[19:0];
        end
      end
      fcca_pkg::OP_END:  store_link(shadow_last, 32'hffff_ffff);
      fcca_pkg::OP_READ: res.read_data = fat_shadow[it.read_addr];
      default: ;
    endcase
    return res;
  endfunction

  // transaction driving and checking

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap <= 0;
    end else if (!item_valid || item_fire) begin
      if (send_gap > 0) begin
        item_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() > 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      take_gap <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_asked) begin
      result_ready <= 1'b0;
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
    end else if (take_gap > 0) begin
      result_ready <= 1'b0;
      take_gap <= take_gap - 1;
    end else begin
      result_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) take_gap <= pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    fcca_pkg::result_t want;
    if (rst) begin
      item_fire <= 1'b0;
      reset_shadow();
    end else begin
      item_fire <= item_valid && item_ready;
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (result.cluster !== want.cluster) begin
            $error("cluster: expected %0h, got %0h", want.cluster, result.cluster);
            failures++;
          end
          if (result.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, result.read_data);
            failures++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
            failures++;
          end
        end
      end
      if (item_valid && item_ready) begin
        expected_results.push_back(predict_result(item));
        items_taken++;
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
  end

  // stimulus

  function automatic logic [12:0] rand_addr();
    return 13'($urandom_range(0, fcca_pkg::FAT_BYTES - 1));
  endfunction

  function automatic logic [12:0] near_addr(int unsigned hint, logic [1:0] fmt);
    int unsigned hi;
    hi = slot_pos(hint, fmt) + 8;
    if (hi > fcca_pkg::FAT_BYTES - 1 || $urandom_range(0, 9) < 3) begin
      hi = fcca_pkg::FAT_BYTES - 1;
    end
    return 13'($urandom_range(0, hi));
  endfunction

  function automatic void queue_op(logic [2:0] op, logic [12:0] addr);
    pending_items.push_back(fcca_pkg::item_t'({op, addr}));
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (IDLE_MARGIN) @(posedge clk);
  endtask

  task automatic write_reg(input fcca_pkg::cfg_reg_t idx, input logic [20:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [1:0] fmt, input logic [20:0] count,
                          input logic [20:0] media_word);
    wait_idle();
    write_reg(fcca_pkg::CFG_FORMAT, 21'(fmt));
    write_reg(fcca_pkg::CFG_COUNT, count);
    write_reg(fcca_pkg::CFG_MEDIA, media_word);
  endtask

  // mostly chains of start, continues and end, with reads near the built entries
  task automatic chain_mix(input int n, input logic [1:0] fmt);
    int made;
    int hint;
    int r;
    int k;
    made = 0;
    hint = 1;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        queue_op(fcca_pkg::OP_CLEAR, rand_addr());
        hint = 1;
        made++;
      end else if (r < 70) begin
        k = $urandom_range(0, 6);
        queue_op(fcca_pkg::OP_START, rand_addr());
        repeat (k) queue_op(fcca_pkg::OP_CONT, rand_addr());
        hint += k + 1;
        made += k + 1;
        if ($urandom_range(0, 4) != 0) begin
          queue_op(fcca_pkg::OP_END, rand_addr());
          made++;
        end
        k = $urandom_range(0, 3);
        repeat (k) queue_op(fcca_pkg::OP_READ, near_addr(hint, fmt));
        made += k;
      end else if (r < 90) begin
        k = $urandom_range(1, 4);
        repeat (k) queue_op(fcca_pkg::OP_READ, near_addr(hint, fmt));
        made += k;
      end else if (r < 95) begin
        queue_op($urandom_range(0, 1) ? fcca_pkg::OP_CONT : fcca_pkg::OP_END, rand_addr());
        made++;
      end else begin
        queue_op(3'($urandom_range(fcca_pkg::OP_START, OP_CODE_MAX)), rand_addr());
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] fmt, input logic [20:0] count,
                           input logic [20:0] media_word, input int n,
                           input bit no_gaps, input bit with_hold);
    int target;
    set_regs(fmt, count, media_word);
    steady = no_gaps;
    queue_op(fcca_pkg::OP_CLEAR, rand_addr());
    chain_mix(n, fmt);
    if (with_hold) begin
      target = items_taken + 10;
      while (items_taken < target) @(posedge clk);
      hold_asked++;
    end
    wait_idle();
    steady = 1'b0;
  endtask

  // a short run of 32-bit allocations, then reads of the last bytes of the store
  task automatic fill_store();
    int r;
    set_regs(FMT32, COUNT_MAX, 21'(DEFAULT_MEDIA));
    queue_op(fcca_pkg::OP_CLEAR, rand_addr());
    repeat (FILL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        queue_op(fcca_pkg::OP_START, rand_addr());
      end else if (r < 96) begin
        queue_op(fcca_pkg::OP_CONT, rand_addr());
      end else begin
        queue_op(fcca_pkg::OP_READ, rand_addr());
      end
    end
    queue_op(fcca_pkg::OP_END, rand_addr());
    for (int a = fcca_pkg::FAT_BYTES - 8; a < fcca_pkg::FAT_BYTES; a++) begin
      queue_op(fcca_pkg::OP_READ, 13'(a));
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = fcca_pkg::CFG_FORMAT;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset contents, first chain, unknown codes, header after clear, link over the header
    queue_op(fcca_pkg::OP_READ, '0);
    queue_op(fcca_pkg::OP_START, '0);
    queue_op(fcca_pkg::OP_CONT, '0);
    queue_op(fcca_pkg::OP_END, '0);
    for (int a = 3; a < 6; a++) queue_op(fcca_pkg::OP_READ, 13'(a));
    for (int k = fcca_pkg::OP_READ + 1; k <= OP_CODE_MAX; k++) queue_op(3'(k), rand_addr());
    queue_op(fcca_pkg::OP_READ, 13'(fcca_pkg::FAT_BYTES - 1));
    queue_op(fcca_pkg::OP_CLEAR, 13'(fcca_pkg::FAT_BYTES - 1));
    for (int a = 0; a < 4; a++) queue_op(fcca_pkg::OP_READ, 13'(a));
    queue_op(fcca_pkg::OP_CONT, '0);
    queue_op(fcca_pkg::OP_READ, 13'd1);
    queue_op(fcca_pkg::OP_READ, 13'd2);
    queue_op(fcca_pkg::OP_END, '0);
    wait_idle();

    // counts too small to allow any advance
    write_reg(fcca_pkg::CFG_COUNT, 21'd0);
    queue_op(fcca_pkg::OP_START, '0);
    wait_idle();
    write_reg(fcca_pkg::CFG_COUNT, 21'd1);
    queue_op(fcca_pkg::OP_CONT, '0);
    queue_op(fcca_pkg::OP_READ, 13'd3);
    wait_idle();
    write_reg(fcca_pkg::CFG_COUNT, 21'd2);
    queue_op(fcca_pkg::OP_CLEAR, '0);
    queue_op(fcca_pkg::OP_START, '0);
    wait_idle();

    run_phase(FMT12, 21'd40, 21'h0, 300, 1'b0, 1'b0);
    run_phase(FMT16, 21'd2, 21'hff, 60, 1'b0, 1'b0);
    run_phase(FMT32, COUNT_MAX, 21'($urandom_range(0, 255)), 300, 1'b0, 1'b1);
    run_phase(FMT32_ALT, 21'd300, 21'h1fff5a, 250, 1'b0, 1'b0);
    run_phase(FMT12, 21'h1fffff, 21'($urandom_range(0, 255)), 300, 1'b1, 1'b0);
    run_phase(FMT16, 21'd100, 21'($urandom_range(0, 255)), 250, 1'b0, 1'b1);
    fill_store();

    wait_idle();
    if (failures == 0 && expected_results.size() == 0) begin
      $display("fat_cluster_chain_allocator_tb passed");
    end else begin
      $display("fat_cluster_chain_allocator_tb failed");
    end
    $finish;
  end

endmodule
